### rtl/core/rmed_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rmed_pkg
// Types and constants shared by the running-median core and its heap unit.
// ----------------------------------------------------------------------------
package rmed_pkg;
	localparam int Capacity  = 1024;
	localparam int ValueBits = 32;
	localparam int HalfDepth = (Capacity + 1) / 2;
	localparam int AddrBits  = $clog2(HalfDepth);
	localparam int CountBits = 11;
	localparam int MedBits   = 33;

	typedef logic signed [ValueBits-1:0] value_t;
	typedef logic [AddrBits-1:0]         addr_t;
	typedef logic [AddrBits:0]           size_t;
	typedef logic [CountBits-1:0]        count_t;

	// heap operation codes
	typedef enum logic [1:0] {
		OP_PUSH    = 2'd0,
		OP_REPLACE = 2'd1
	} heap_op_t;

	typedef struct packed {
		logic     start;
		heap_op_t op;
		size_t    size;   // entries before op (push) or held (replace)
		value_t   value;
	} heap_cmd_t;

	typedef struct packed {
		logic   done;
		value_t old_top;  // current top; the caller latches it before a replace
	} heap_rsp_t;

	typedef enum logic [3:0] {
		HS_IDLE,
		HS_UP_RD,
		HS_UP_CMP,
		HS_RT_RD,
		HS_RT_WAIT,
		HS_DN_RD,
		HS_DN_WAIT,
		HS_DN_CMP,
		HS_DN_RWAIT
	} heap_state_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_TOPS,
		ST_FIRST,
		ST_SECOND,
		ST_RDTOP,
		ST_RDWAIT,
		ST_OUT
	} top_state_t;
endpackage
`default_nettype wire

### rtl/core/rmed_heap.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rmed_heap
// One binary heap (max or min) in a synchronous RAM with one read and one
// write port. Push sifts up, replace swaps the top and sifts down. Top is
// kept in a register too.
// ----------------------------------------------------------------------------
module rmed_heap (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               is_max,
	input  wire rmed_pkg::heap_cmd_t cmd,
	output rmed_pkg::heap_rsp_t     rsp,
	output rmed_pkg::value_t        top
);
	import rmed_pkg::*;

	value_t mem [HalfDepth];
	value_t rd_data_q;

	heap_state_t state_q, state_d;
	addr_t  idx_q, idx_d;          // hole position
	size_t  n_q, n_d;
	value_t v_q, v_d;              // value being placed
	value_t best_q, best_d;        // best child value
	addr_t  best_i_q, best_i_d;
	value_t top_q, top_d;
	logic   we;
	addr_t  waddr, raddr;
	value_t wdata;
	logic   done;
	logic [AddrBits:0] lchild;

	function automatic logic above(input value_t a, input value_t b, input logic mx);
		above = mx ? (a > b) : (a < b);
	endfunction

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		rd_data_q <= mem[raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= HS_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		idx_q    <= idx_d;
		n_q      <= n_d;
		v_q      <= v_d;
		best_q   <= best_d;
		best_i_q <= best_i_d;
		top_q    <= top_d;
	end

	assign lchild = {idx_q, 1'b1};

	always_comb begin
		state_d  = state_q;
		idx_d    = idx_q;
		n_d      = n_q;
		v_d      = v_q;
		best_d   = best_q;
		best_i_d = best_i_q;
		top_d    = top_q;
		we       = 1'b0;
		waddr    = idx_q;
		wdata    = v_q;
		raddr    = idx_q;
		done     = 1'b0;
		unique case (state_q)
			HS_IDLE: begin
				if (cmd.start) begin
					v_d = cmd.value;
					n_d = cmd.size;
					if (cmd.op == OP_PUSH) begin
						idx_d   = cmd.size[AddrBits-1:0];
						state_d = HS_UP_RD;
					end else begin
						idx_d   = '0;
						top_d   = cmd.value;
						state_d = HS_DN_RD;
					end
				end
			end
			HS_UP_RD: begin
				if (idx_q == '0) begin
					we      = 1'b1;
					top_d   = v_q;
					done    = 1'b1;
					state_d = HS_IDLE;
				end else begin
					raddr   = addr_t'((idx_q - 1'b1) >> 1);
					state_d = HS_UP_CMP;
				end
			end
			HS_UP_CMP: begin
				if (above(v_q, rd_data_q, is_max)) begin
					we      = 1'b1;
					wdata   = rd_data_q;
					idx_d   = addr_t'((idx_q - 1'b1) >> 1);
					state_d = HS_UP_RD;
				end else begin
					we      = 1'b1;
					done    = 1'b1;
					state_d = HS_IDLE;
				end
			end
			HS_DN_RD: begin
				if (size_t'(lchild) >= n_q) begin
					we      = 1'b1;
					done    = 1'b1;
					state_d = HS_IDLE;
				end else begin
					raddr   = lchild[AddrBits-1:0];
					state_d = HS_DN_WAIT;
				end
			end
			HS_DN_WAIT: begin
				best_d   = rd_data_q;
				best_i_d = lchild[AddrBits-1:0];
				if (size_t'(lchild) + 1'b1 < n_q) begin
					raddr   = addr_t'(lchild + 1'b1);
					state_d = HS_DN_RWAIT;
				end else begin
					state_d = HS_DN_CMP;
				end
			end
			HS_DN_RWAIT: begin
				if (above(rd_data_q, best_q, is_max)) begin
					best_d   = rd_data_q;
					best_i_d = addr_t'(lchild + 1'b1);
				end
				state_d = HS_DN_CMP;
			end
			HS_DN_CMP: begin
				if (above(best_q, v_q, is_max)) begin
					we    = 1'b1;
					wdata = best_q;
					if (idx_q == '0)
						top_d = best_q;
					idx_d   = best_i_q;
					state_d = HS_DN_RD;
				end else begin
					we      = 1'b1;
					done    = 1'b1;
					state_d = HS_IDLE;
				end
			end
			default: state_d = HS_IDLE;
		endcase
	end

	// old top is latched by the caller before replace; report current top
	assign rsp.done    = done;
	assign rsp.old_top = top_q;
	assign top         = (state_q == HS_UP_RD && idx_q == '0) ? v_q : top_q;
endmodule
`default_nettype wire

### rtl/core/running_median_two_heaps.sv
`default_nettype none
// ----------------------------------------------------------------------------
// running_median_two_heaps
// Running median over a stream of signed samples, kept as a lower max-heap
// and an upper min-heap in two block RAMs.
// ----------------------------------------------------------------------------
// One transfer in gives one transfer out. An insert takes one or two heap
// operations run one after the other. Sifting up reads the parent, then
// compares and writes, per level; sifting down reads left, reads right (if
// present), then compares and writes. Heap time is shortest for the first
// sample and longest for a replace through 9 levels of the lower heap
// followed by a 9-level push into the upper heap. out_valid is registered
// after ST_TOPS, the heap operations, ST_RDTOP and ST_RDWAIT (a rejected
// sample skips the heap work), and the input stays stalled until the result
// transfers. One item is worked on at a time. When 1024 values are held the
// sample is dropped and rejected is set. median_doubled is twice the median
// (one fractional bit).
module running_median_two_heaps (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     in_valid,
	output logic                          in_stall,
	input  wire logic signed [31:0]       value,
	output logic                          out_valid,
	input  wire logic                     out_stall,
	output logic signed [32:0]            median_doubled,
	output logic [10:0]                   count,
	output logic                          rejected
);
	import rmed_pkg::*;

	top_state_t state_q, state_d;
	count_t n_q, n_d;
	value_t v_q;
	value_t pass_q;
	logic   rej_q, rej_d;
	logic   out_v_q;
	logic signed [MedBits-1:0] med_q, med_d;
	logic signed [MedBits-1:0] med_calc;

	heap_cmd_t lo_cmd, up_cmd;
	heap_rsp_t lo_rsp, up_rsp;
	value_t    lo_top, up_top;

	// plan of the insert
	logic second_q, second_d;  // a push follows the first op
	logic first_lo_q, first_lo_d; // first op on lower heap
	heap_op_t first_op_q, first_op_d;

	size_t lo_n, up_n;
	logic  acc;

	assign lo_n = size_t'((n_q + 1'b1) >> 1);
	assign up_n = size_t'(n_q >> 1);
	assign acc  = in_valid && !in_stall;

	rmed_heap u_lo (.clk, .arst_n, .is_max(1'b1), .cmd(lo_cmd), .rsp(lo_rsp), .top(lo_top));
	rmed_heap u_up (.clk, .arst_n, .is_max(1'b0), .cmd(up_cmd), .rsp(up_rsp), .top(up_top));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			n_q     <= '0;
			out_v_q <= 1'b0;
		end else begin
			state_q <= state_d;
			n_q     <= n_d;
			if (state_q == ST_OUT && !out_v_q)
				out_v_q <= 1'b1;
			else if (out_v_q && !out_stall)
				out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (acc)
			v_q <= value;
		rej_q      <= rej_d;
		med_q      <= med_d;
		second_q   <= second_d;
		first_lo_q <= first_lo_d;
		first_op_q <= first_op_d;
		if (state_q == ST_FIRST && first_op_q == OP_REPLACE)
			pass_q <= first_lo_q ? lo_top : up_top;
	end

	always_comb begin
		if (n_q[0])
			med_calc = MedBits'(lo_top) <<< 1;
		else
			med_calc = MedBits'(lo_top) + MedBits'(up_top);
	end

	always_comb begin
		state_d    = state_q;
		n_d        = n_q;
		rej_d      = rej_q;
		med_d      = med_q;
		second_d   = second_q;
		first_lo_d = first_lo_q;
		first_op_d = first_op_q;
		lo_cmd     = '0;
		up_cmd     = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (acc)
					state_d = ST_TOPS;
			end
			ST_TOPS: begin
				rej_d      = 1'b0;
				second_d   = 1'b0;
				first_op_d = OP_PUSH;
				first_lo_d = 1'b1;
				if (n_q >= count_t'(Capacity)) begin
					rej_d   = 1'b1;
					state_d = ST_RDTOP;
				end else begin
					state_d = ST_FIRST;
					if (lo_n == '0 || v_q <= lo_top) begin
						if (lo_n > up_n) begin
							first_lo_d = v_q < lo_top;
							first_op_d = (v_q < lo_top) ? OP_REPLACE : OP_PUSH;
							second_d   = v_q < lo_top;
						end
					end else if (lo_n > up_n) begin
						first_lo_d = 1'b0;
					end else if (up_n != '0 && v_q > up_top) begin
						first_lo_d = 1'b0;
						first_op_d = OP_REPLACE;
						second_d   = 1'b1;
					end
				end
			end
			ST_FIRST: begin
				if (first_lo_q) begin
					lo_cmd.start = 1'b1;
					lo_cmd.op    = first_op_q;
					lo_cmd.size  = lo_n;
					lo_cmd.value = v_q;
				end else begin
					up_cmd.start = 1'b1;
					up_cmd.op    = first_op_q;
					up_cmd.size  = up_n;
					up_cmd.value = v_q;
				end
				state_d = ST_SECOND;
			end
			ST_SECOND: begin
				if (lo_rsp.done || up_rsp.done) begin
					if (second_q) begin
						second_d = 1'b0;
						if (first_lo_q) begin
							up_cmd.start = 1'b1;
							up_cmd.size  = up_n;
							up_cmd.value = pass_q;
						end else begin
							lo_cmd.start = 1'b1;
							lo_cmd.size  = lo_n;
							lo_cmd.value = pass_q;
						end
					end else begin
						n_d     = n_q + 1'b1;
						state_d = ST_RDTOP;
					end
				end
			end
			ST_RDTOP: state_d = ST_RDWAIT;
			ST_RDWAIT: begin
				med_d   = med_calc;
				state_d = ST_OUT;
			end
			ST_OUT: begin
				if (out_v_q && !out_stall)
					state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	assign in_stall       = (state_q != ST_IDLE);
	assign out_valid      = out_v_q;
	assign median_doubled = med_q;
	assign count          = n_q;
	assign rejected       = rej_q;
endmodule
`default_nettype wire

### rtl/core/rmed_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rmed_port_props
// Port-level checks for the running-median core.
// ----------------------------------------------------------------------------
module rmed_port_props (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        in_valid,
	input wire logic        in_stall,
	input wire logic        out_valid,
	input wire logic        out_stall,
	input wire logic [32:0] median_doubled,
	input wire logic [10:0] count,
	input wire logic        rejected
);
	// one item in flight: no input transfer while a result waits
	a_one: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> in_stall) else $error("input taken while result pending");

	// a stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=>
			(out_valid && $stable(median_doubled) && $stable(count) && $stable(rejected)))
		else $error("result changed while stalled");

	a_rej: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && rejected) |-> (count == 11'd1024))
		else $error("reject below capacity");

	a_nz: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !rejected) |-> (count != 11'd0))
		else $error("empty after insert");
endmodule

bind running_median_two_heaps rmed_port_props u_rmed_port_props (
	.clk, .arst_n, .in_valid, .in_stall, .out_valid, .out_stall,
	.median_doubled, .count, .rejected
);
`default_nettype wire

### tb/rmed_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// rmed_checker
// Watches both channels of the running-median core, keeps its own sorted copy
// of the held samples to predict each result, and compares field by field.
// ----------------------------------------------------------------------------
module rmed_checker (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	input  wire logic               in_stall,
	input  wire logic signed [31:0] value,
	input  wire logic               out_valid,
	input  wire logic               out_stall,
	input  wire logic signed [32:0] median_doubled,
	input  wire logic [10:0]        count,
	input  wire logic               rejected,
	output int                      errors,
	output int                      pending,
	output int                      results_seen,
	output int                      rejects_seen
);
	import rmed_pkg::*;

	typedef struct {
		logic signed [32:0] med;
		logic [10:0]        cnt;
		logic               rej;
	} median_result_t;

	// held samples kept in ascending order
	longint         sorted_samples[$];
	median_result_t median_queue[$];

	function automatic median_result_t insert_and_median(longint v);
		median_result_t r;
		int n;
		int pos;
		n = sorted_samples.size();
		r.rej = 1'b0;
		if (n >= Capacity) begin
			r.rej = 1'b1;
		end else begin
			pos = 0;
			while (pos < n && sorted_samples[pos] < v)
				pos++;
			sorted_samples.insert(pos, v);
			n++;
		end
		r.cnt = n[10:0];
		if (n == 0)
			r.med = '0;
		else if (n % 2)
			r.med = 33'(2 * sorted_samples[(n - 1) / 2]);
		else
			r.med = 33'(sorted_samples[n / 2 - 1] + sorted_samples[n / 2]);
		return r;
	endfunction

	initial errors = 0;
	initial pending = 0;
	initial results_seen = 0;
	initial rejects_seen = 0;

	always @(posedge clk) begin
		median_result_t exp_r;
		if (arst_n) begin
			if (in_valid && !in_stall)
				median_queue.push_back(insert_and_median(longint'(value)));
			if (out_valid && !out_stall) begin
				results_seen++;
				if (rejected)
					rejects_seen++;
				if (median_queue.size() == 0) begin
					$error("result with nothing expected: median_doubled=%0d", median_doubled);
					errors++;
				end else begin
					exp_r = median_queue.pop_front();
					if (median_doubled !== exp_r.med) begin
						$error("median_doubled expected %0d actual %0d", exp_r.med,
							median_doubled);
						errors++;
					end
					if (count !== exp_r.cnt) begin
						$error("count expected %0d actual %0d", exp_r.cnt, count);
						errors++;
					end
					if (rejected !== exp_r.rej) begin
						$error("rejected expected %0b actual %0b", exp_r.rej, rejected);
						errors++;
					end
				end
			end
			pending = median_queue.size();
		end
	end
endmodule

### tb/tb_running_median_two_heaps.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_running_median_two_heaps
// Drives samples into the running-median core under several idle and stall
// mixes, fills the store past capacity and checks every result.
// ----------------------------------------------------------------------------
module tb_running_median_two_heaps;
	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               in_valid = 1'b0;
	logic               in_stall;
	logic signed [31:0] value = '0;
	logic               out_valid;
	logic               out_stall = 1'b0;
	logic signed [32:0] median_doubled;
	logic [10:0]        count;
	logic               rejected;
	int                 errors;
	int                 pending;
	int                 results_seen;
	int                 rejects_seen;

	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	bit hold_off = 1'b0;
	bit stim_done = 1'b0;

	always #1 clk = ~clk;

	running_median_two_heaps dut (
		.clk, .arst_n, .in_valid, .in_stall, .value,
		.out_valid, .out_stall, .median_doubled, .count, .rejected
	);

	rmed_checker checker_i (
		.clk, .arst_n, .in_valid, .in_stall, .value,
		.out_valid, .out_stall, .median_doubled, .count, .rejected,
		.errors, .pending, .results_seen, .rejects_seen
	);

	// receiver: random stall, or a long hold-off when asked
	always @(posedge clk) begin
		if (hold_off)
			out_stall <= 1'b1;
		else
			out_stall <= ($urandom_range(99) < recv_stall_pct);
	end

	function automatic logic [31:0] random_sample();
		case ($urandom_range(5))
			0: return 32'h8000_0000 | $urandom_range(3);
			1: return 32'h7fff_fffc | $urandom_range(3);
			2: return 32'($signed($urandom_range(20)) - 10);
			default: return $urandom();
		endcase
	endfunction

	// one transfer; idle gap decided before offering
	task automatic send_sample(logic [31:0] v);
		while ($urandom_range(99) < send_idle_pct) begin
			@(posedge clk);
			in_valid <= 1'b0;
		end
		@(posedge clk);
		in_valid <= 1'b1;
		value <= v;
		do @(posedge clk); while (in_stall);
		in_valid <= 1'b0;
		#0;
	endtask

	// send_sample leaves in_valid low at the next edge, keeping one NBA per step
	task automatic send_random(int n);
		repeat (n) send_sample(random_sample());
	endtask

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		// directed: extremes, ties, sign bits
		send_sample(32'h8000_0000);
		send_sample(32'h7fff_ffff);
		send_sample(32'h7fff_ffff);
		send_sample(32'h8000_0000);
		send_sample(32'h0);
		send_sample(32'h0);
		send_sample(32'hffff_ffff);
		send_sample(32'h1);
		send_sample(32'h5555_5555);
		send_sample(32'haaaa_aaaa);
		send_sample(32'h0);
		send_sample(32'h0);
		// random phases
		send_idle_pct = 0; recv_stall_pct = 0;   send_random(250);
		send_idle_pct = 58; recv_stall_pct = 0;  send_random(200);
		send_idle_pct = 0; recv_stall_pct = 58;  send_random(200);
		send_idle_pct = 33; recv_stall_pct = 33; send_random(200);
		// long receiver hold-off while samples keep coming
		fork
			begin
				hold_off = 1'b1;
				repeat (400) @(posedge clk);
				hold_off = 1'b0;
			end
			begin
				send_idle_pct = 0; recv_stall_pct = 20;
				send_random(200);
			end
		join
		// store is full now: these are all rejected
		send_random(60);
		stim_done = 1'b1;
	end

	initial begin
		wait (stim_done);
		while (pending != 0) @(posedge clk);
		repeat (100) @(posedge clk);
		$display("covered %0d results, %0d of them rejected on a full store, across idle and stall mixes",
			results_seen, rejects_seen);
		if (errors == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

	initial begin
		#2000000;
		$display("CHECKS FAILED");
		$finish;
	end
endmodule
